// File: hw/rtl/shmol_pkg.sv
// ============================================================================
// Smooth Heaviside mollifier package
// Shared constants, types and the arctangent table of the CORDIC pipeline.
// ============================================================================
`default_nettype none

package shmol_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 16;

    // Working format of the sine path is Q30.
    localparam int WORK_FRAC    = 30;
    localparam int ATAN_ENTRIES = 30;
    localparam int CORDIC_W     = 34;

    // Register stages before and after the CORDIC rotation stages.
    localparam int PRE_STAGES  = 5;
    localparam int POST_STAGES = 3;

    localparam logic [31:0] GAIN_Q30   = 32'd652032874;
    localparam logic [31:0] PI_Q30     = 32'd3373259426;
    localparam logic [28:0] INV_PI_Q30 = 29'd341782638;
    localparam logic [30:0] ONE_Q30    = 31'd1073741824;
    localparam logic [16:0] MASK_ONE   = 17'd65536;

    typedef enum logic [1:0] {
        CFG_MOLLIFY_WIDTH     = 2'd0,
        CFG_INV_MOLLIFY_WIDTH = 2'd1,
        CFG_ACTIVE_DISTANCE   = 2'd2
    } t_cfg_index;

    // Per-request side information that rides along the pipeline.
    typedef struct packed {
        logic        neg;
        logic        above;
        logic        below;
        logic        active;
        logic        last;
        logic [30:0] u30;
    } t_side;

    // atan(2^-i) in Q30, rounded to nearest.
    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2
    };

endpackage

`default_nettype wire

// File: hw/rtl/shmol_cordic.sv
// ============================================================================
// Smooth Heaviside mollifier CORDIC
// Rotation-mode CORDIC, one register stage per iteration, giving sin(theta).
// ============================================================================
`default_nettype none

module shmol_cordic #(
    parameter int STAGES = shmol_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic [STAGES-1:0]                        i_en,
    input  wire logic [31:0]                              i_theta,
    input  wire shmol_pkg::t_side                         i_side,
    output logic signed [shmol_pkg::CORDIC_W-1:0]         o_sin,
    output shmol_pkg::t_side                              o_side
);

    localparam int W = shmol_pkg::CORDIC_W;

    logic signed [W-1:0] r_x    [STAGES];
    logic signed [W-1:0] r_y    [STAGES];
    logic signed [W-1:0] r_z    [STAGES];
    shmol_pkg::t_side    r_side [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [W-1:0] ATAN =
            $signed({{(W-32){1'b0}}, shmol_pkg::ATAN_Q30[i]});

        logic signed [W-1:0] w_x;
        logic signed [W-1:0] w_y;
        logic signed [W-1:0] w_z;
        shmol_pkg::t_side    w_side;
        logic signed [W-1:0] n_x;
        logic signed [W-1:0] n_y;
        logic signed [W-1:0] n_z;

        if (i == 0) begin : g_first
            assign w_x    = $signed({{(W-32){1'b0}}, shmol_pkg::GAIN_Q30});
            assign w_y    = '0;
            assign w_z    = $signed({{(W-32){1'b0}}, i_theta});
            assign w_side = i_side;
        end else begin : g_next
            assign w_x    = r_x[i-1];
            assign w_y    = r_y[i-1];
            assign w_z    = r_z[i-1];
            assign w_side = r_side[i-1];
        end

        always_comb begin
            if (!w_z[W-1]) begin
                n_x = w_x - (w_y >>> i);
                n_y = w_y + (w_x >>> i);
                n_z = w_z - ATAN;
            end else begin
                n_x = w_x + (w_y >>> i);
                n_y = w_y - (w_x >>> i);
                n_z = w_z + ATAN;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[i]) begin
                r_x[i]    <= n_x;
                r_y[i]    <= n_y;
                r_z[i]    <= n_z;
                r_side[i] <= w_side;
            end
        end
    end

    assign o_sin  = r_y[STAGES-1];
    assign o_side = r_side[STAGES-1];

endmodule

`default_nettype wire

// File: hw/rtl/smooth_heaviside_mollifier_top.sv
// ============================================================================
// Smooth Heaviside mollifier
// Penalization mask chi and active flag per particle distance.
// ============================================================================
// Usage: one request per particle enters on the in channel (surface distance
// in Q15.16 and a last-particle marker). Each request produces exactly one
// result on the out channel: chi in Q1.16, the active flag and the marker.
// Results leave in request order.
// The pipeline is built from register stages: five stages form |u| and the
// CORDIC angle, one stage per CORDIC iteration, and three stages scale the
// sine and round the mask.
// Throughput is one request per cycle while results are taken; every stage is
// a register with its own valid bit, so a request may enter in each cycle.
// When the receiver holds ready low, the output stage holds its result and
// empty stages behind it keep filling; o_in_ready falls only once every
// stage holds a request. Nothing is dropped or repeated.
// The configuration channel is always ready; registers reset to h = 1.0,
// 1/h = 1.0 and activation distance 1.0. Reset clears all valid bits.
// ============================================================================
`default_nettype none

module smooth_heaviside_mollifier_top #(
    parameter int CORDIC_STAGES = shmol_pkg::CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = shmol_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [31:0] i_surface_distance,
    input  wire logic               i_last_particle,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [16:0]             o_mask_value,
    output logic                    o_is_active,
    output logic                    o_last_out,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    localparam int ST_A      = 0;
    localparam int ST_B      = 1;
    localparam int ST_C      = 2;
    localparam int ST_D      = 3;
    localparam int ST_E      = 4;
    localparam int ST_CORDIC = shmol_pkg::PRE_STAGES;
    localparam int ST_P1     = ST_CORDIC + CORDIC_STAGES;
    localparam int ST_P2     = ST_P1 + 1;
    localparam int ST_OUT    = ST_P2 + 1;
    localparam int NUM_ST    = shmol_pkg::PRE_STAGES + CORDIC_STAGES + shmol_pkg::POST_STAGES;

    localparam logic [63:0]          RND_U    = 64'd1 << (31 - FRAC_BITS);
    localparam logic [63:0]          ONE_F64  = 64'd1 << FRAC_BITS;
    localparam logic [FRAC_BITS:0]   ONE_F    = ONE_F64[FRAC_BITS:0];
    localparam logic [FRAC_BITS+31:0] RND_TH  = (FRAC_BITS+32)'(1) << (FRAC_BITS - 1);

    // Configuration registers.
    logic        [30:0] r_mollify_width;
    logic        [31:0] r_inv_mollify_width;
    logic signed [31:0] r_active_distance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mollify_width     <= 31'd65536;
            r_inv_mollify_width <= 32'd65536;
            r_active_distance   <= 32'sd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                shmol_pkg::CFG_MOLLIFY_WIDTH:     r_mollify_width     <= i_cfg_data[30:0];
                shmol_pkg::CFG_INV_MOLLIFY_WIDTH: r_inv_mollify_width <= i_cfg_data;
                shmol_pkg::CFG_ACTIVE_DISTANCE:   r_active_distance   <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Stage handshake: a stage loads when it is empty or its content moves on.
    logic [NUM_ST-1:0] r_valid;
    logic [NUM_ST-1:0] w_en;

    assign w_en[NUM_ST-1] = !r_valid[NUM_ST-1] || i_out_ready;
    for (genvar k = 0; k < NUM_ST - 1; k++) begin : g_en
        assign w_en[k] = !r_valid[k] || w_en[k+1];
    end

    assign o_in_ready  = w_en[ST_A];
    assign o_out_valid = r_valid[ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_ST; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // Stage A: band compares, activation compare and |R|.
    logic signed [32:0] w_a_dist;
    logic signed [33:0] w_a_sum;
    shmol_pkg::t_side   n_a_side;
    logic        [31:0] n_a_mag;
    shmol_pkg::t_side   r_a_side;
    logic        [31:0] r_a_mag;

    always_comb begin
        w_a_dist        = {i_surface_distance[31], i_surface_distance};
        w_a_sum         = {{2{i_surface_distance[31]}}, i_surface_distance}
                          + $signed({3'b000, r_mollify_width});
        n_a_mag         = i_surface_distance[31] ? 32'(-w_a_dist) : 32'(w_a_dist);
        n_a_side.neg    = i_surface_distance[31];
        n_a_side.above  = i_surface_distance > $signed({1'b0, r_mollify_width});
        n_a_side.below  = w_a_sum[33];
        n_a_side.active = i_surface_distance < r_active_distance;
        n_a_side.last   = i_last_particle;
        n_a_side.u30    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_A]) begin
            r_a_side <= n_a_side;
            r_a_mag  <= n_a_mag;
        end
    end

    // Stage B: |R| times the reciprocal.
    logic [63:0]      n_b_prod;
    logic [63:0]      r_b_prod;
    shmol_pkg::t_side r_b_side;

    assign n_b_prod = 64'(r_a_mag) * 64'(r_inv_mollify_width);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_B]) begin
            r_b_prod <= n_b_prod;
            r_b_side <= r_a_side;
        end
    end

    // Stage C: round to FRAC_BITS fractional bits and saturate |u| to 1.0.
    logic [63:0]        w_c_rnd;
    logic [63:0]        w_c_full;
    logic [FRAC_BITS:0] n_c_a;
    shmol_pkg::t_side   n_c_side;
    logic [FRAC_BITS:0] r_c_a;
    shmol_pkg::t_side   r_c_side;

    always_comb begin
        w_c_rnd  = r_b_prod + RND_U;
        w_c_full = w_c_rnd >> (32 - FRAC_BITS);
        n_c_a    = (w_c_full > ONE_F64) ? ONE_F : w_c_full[FRAC_BITS:0];
        n_c_side = r_b_side;
        n_c_side.u30 = {n_c_a, {(shmol_pkg::WORK_FRAC - FRAC_BITS){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_C]) begin
            r_c_a    <= n_c_a;
            r_c_side <= n_c_side;
        end
    end

    // Stage D: fold |u| into [0, 0.5], where sin(pi*u) is symmetric.
    logic [FRAC_BITS:0]   w_d_rest;
    logic [FRAC_BITS:0]   w_d_b;
    logic [FRAC_BITS-1:0] r_d_b;
    shmol_pkg::t_side     r_d_side;

    always_comb begin
        w_d_rest = ONE_F - r_c_a;
        w_d_b    = (r_c_a < w_d_rest) ? r_c_a : w_d_rest;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_D]) begin
            r_d_b    <= w_d_b[FRAC_BITS-1:0];
            r_d_side <= r_c_side;
        end
    end

    // Stage E: angle pi*b in Q30, rounded.
    logic [FRAC_BITS+31:0] w_e_prod;
    logic [FRAC_BITS+31:0] w_e_sum;
    logic [31:0]           r_e_theta;
    shmol_pkg::t_side      r_e_side;

    always_comb begin
        w_e_prod = (FRAC_BITS+32)'(r_d_b) * (FRAC_BITS+32)'(shmol_pkg::PI_Q30);
        w_e_sum  = w_e_prod + RND_TH;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_E]) begin
            r_e_theta <= w_e_sum[FRAC_BITS+31:FRAC_BITS];
            r_e_side  <= r_d_side;
        end
    end

    // CORDIC rotation stages.
    logic signed [shmol_pkg::CORDIC_W-1:0] w_sin;
    shmol_pkg::t_side                      w_cordic_side;

    shmol_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_en    (w_en[ST_CORDIC +: CORDIC_STAGES]),
        .i_theta (r_e_theta),
        .i_side  (r_e_side),
        .o_sin   (w_sin),
        .o_side  (w_cordic_side)
    );

    // Stage P1: clamp the sine to [0, 1.0] and scale by 1/pi.
    logic [30:0]      w_p1_s;
    logic [59:0]      w_p1_prod;
    logic [28:0]      r_p1_sop;
    shmol_pkg::t_side r_p1_side;

    always_comb begin
        if (w_sin[shmol_pkg::CORDIC_W-1]) begin
            w_p1_s = '0;
        end else if (w_sin > $signed({3'b000, shmol_pkg::ONE_Q30})) begin
            w_p1_s = shmol_pkg::ONE_Q30;
        end else begin
            w_p1_s = w_sin[30:0];
        end
        w_p1_prod = 60'(w_p1_s) * 60'(shmol_pkg::INV_PI_Q30);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_P1]) begin
            r_p1_sop  <= w_p1_prod[58:30];
            r_p1_side <= w_cordic_side;
        end
    end

    // Stage P2: t = 1 - u - sin(pi*u)/pi, negative values cleared.
    logic signed [33:0] w_p2_one;
    logic signed [33:0] w_p2_terms;
    logic signed [33:0] w_p2_t;
    logic        [31:0] r_p2_t;
    shmol_pkg::t_side   r_p2_side;

    always_comb begin
        w_p2_one   = $signed({3'b000, shmol_pkg::ONE_Q30});
        w_p2_terms = $signed({3'b000, r_p1_side.u30}) + $signed({5'b00000, r_p1_sop});
        w_p2_t     = r_p1_side.neg ? (w_p2_one + w_p2_terms) : (w_p2_one - w_p2_terms);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_P2]) begin
            r_p2_t    <= w_p2_t[33] ? 32'd0 : w_p2_t[31:0];
            r_p2_side <= r_p1_side;
        end
    end

    // Output stage: halve and round to Q1.16, clamp, then apply the band limits.
    logic [32:0] w_o_rnd;
    logic [17:0] w_o_q16;
    logic [16:0] w_o_band;
    logic [16:0] n_o_mask;
    logic [16:0] r_o_mask;
    logic        r_o_active;
    logic        r_o_last;

    always_comb begin
        w_o_rnd  = {1'b0, r_p2_t} + 33'd16384;
        w_o_q16  = w_o_rnd[32:15];
        w_o_band = (w_o_q16 > {1'b0, shmol_pkg::MASK_ONE}) ? shmol_pkg::MASK_ONE
                                                             : w_o_q16[16:0];
        if (r_p2_side.above) begin
            n_o_mask = '0;
        end else if (r_p2_side.below) begin
            n_o_mask = shmol_pkg::MASK_ONE;
        end else begin
            n_o_mask = w_o_band;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            r_o_mask   <= n_o_mask;
            r_o_active <= r_p2_side.active;
            r_o_last   <= r_p2_side.last;
        end
    end

    assign o_mask_value = r_o_mask;
    assign o_is_active  = r_o_active;
    assign o_last_out   = r_o_last;

endmodule

`default_nettype wire

// File: tb/sv/tb_smooth_heaviside_mollifier_top.sv
`timescale 1ns / 100ps
// ============================================================================
// Testbench for the smooth Heaviside mollifier
// Streams particle distances through the block under several register
// settings, predicts chi, the active flag and the marker for every request,
// and compares each result in order with random stalls on both channels.
// ============================================================================

module tb_smooth_heaviside_mollifier_top;

    localparam int N_ROT      = shmol_pkg::CORDIC_STAGES_DEF;
    localparam int FRAC       = shmol_pkg::FRAC_BITS_DEF;
    localparam int LATENCY    = N_ROT + 8;
    localparam int CLK_PERIOD = 4;
    localparam int N_RANDOM   = 230;

    localparam longint CORDIC_GAIN   = 64'sd652032874;
    localparam longint PI_SCALED     = 64'sd3373259426;
    localparam longint INV_PI_SCALED = 64'sd341782638;
    localparam longint UNITY_Q30     = 64'sd1073741824;

    typedef struct {
        logic signed [31:0] distance;
        logic               last;
        int unsigned        gap;
    } t_particle;

    typedef struct {
        logic signed [31:0] distance;
        logic [16:0]        mask;
        logic               active;
        logic               last;
    } t_chi_result;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid  = 1'b0;
    logic signed [31:0] in_dist   = '0;
    logic               in_last   = 1'b0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data  = '0;

    wire                o_in_ready;
    wire                o_out_valid;
    wire [16:0]         o_mask_value;
    wire                o_is_active;
    wire                o_last_out;
    wire                o_cfg_ready;

    // Register copies, kept in step with every accepted configuration write.
    logic [30:0]        width_q = 31'd65536;
    logic [31:0]        inv_q   = 32'd65536;
    logic signed [31:0] act_q   = 32'sd65536;

    longint      atan_q30 [30];
    t_particle   particle_queue [$];
    t_chi_result chi_pending [$];
    int          n_errors  = 0;
    int          n_sent    = 0;
    int          n_recv    = 0;
    int unsigned send_wait = 0;
    int unsigned rcv_gap   = 0;
    logic        sink_hold = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    smooth_heaviside_mollifier_top #(
        .CORDIC_STAGES(N_ROT),
        .FRAC_BITS    (FRAC)
    ) DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_surface_distance(in_dist),
        .i_last_particle   (in_last),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_mask_value      (o_mask_value),
        .o_is_active       (o_is_active),
        .o_last_out        (o_last_out),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        n_errors++;
    endtask

    // atan(2^-i) in Q30 from its power series, summed with 62 fractional bits; pi/4 for i = 0.
    function automatic longint atan_pow2(input int unsigned i);
        longint sum;
        longint part;
        bit     neg;
        if (i == 0) begin
            return (PI_SCALED + 2) / 4;
        end
        sum = 0;
        neg = 1'b0;
        for (int unsigned k = 1; k * i <= 62; k += 2) begin
            part = longint'((64'd1 << (62 - k * i)) / k);
            sum  = neg ? sum - part : sum + part;
            neg  = ~neg;
        end
        return (sum + (64'sd1 <<< 31)) >>> 32;
    endfunction

    // Rotation-mode CORDIC; angle in [0, pi/2] and sine, both Q30.
    function automatic longint cordic_sine(input longint angle);
        longint x, y, z, xs, ys;
        x = CORDIC_GAIN;
        y = 0;
        z = angle;
        for (int i = 0; i < N_ROT && i < 30; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - atan_q30[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + atan_q30[i];
            end
        end
        if (y < 0) y = 0;
        if (y > UNITY_Q30) y = UNITY_Q30;
        return y;
    endfunction

    // chi = 0.5 * (1 - u - sin(pi u) / pi) for a distance inside the band.
    function automatic logic [16:0] band_chi(input longint r);
        longint unsigned mag, prod;
        longint a, b, one_f, theta, s, sop, u30, t;
        mag   = (r < 0) ? -r : r;
        prod  = mag * {32'd0, inv_q};
        one_f = longint'(1) <<< FRAC;
        a     = longint'((prod + (64'd1 << (31 - FRAC))) >> (32 - FRAC));
        if (a > one_f) a = one_f;
        b     = (a < one_f - a) ? a : one_f - a;
        theta = (b * PI_SCALED + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        s     = cordic_sine(theta);
        sop   = (s * INV_PI_SCALED) >>> 30;
        u30   = a <<< (30 - FRAC);
        if (r < 0) begin
            u30 = -u30;
            sop = -sop;
        end
        t = UNITY_Q30 - u30 - sop;
        if (t < 0) t = 0;
        t = (t + (longint'(1) <<< 14)) >>> 15;
        if (t > 65536) t = 65536;
        return t[16:0];
    endfunction

    function automatic t_chi_result predict_chi(input logic signed [31:0] distance,
                                                input logic last);
        t_chi_result res;
        longint      r, h;
        r            = longint'(distance);
        h            = longint'(width_q);
        res.distance = distance;
        res.last     = last;
        res.active   = (distance < act_q);
        if (r > h) begin
            res.mask = 17'd0;
        end else if (r < -h) begin
            res.mask = 17'd65536;
        end else begin
            res.mask = band_chi(r);
        end
        return res;
    endfunction

    // Mix of uniform words, points inside the band, the band edges, points
    // around the activation threshold for the current setting and points near zero.
    function automatic logic signed [31:0] pick_distance();
        longint h, v;
        int     sel;
        h   = longint'(width_q);
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1: v = longint'($signed($urandom()));
            7: begin
                case ($urandom_range(0, 6))
                    0: v = h;
                    1: v = -h;
                    2: v = h + 1;
                    3: v = -h - 1;
                    4: v = h - 1;
                    5: v = -h + 1;
                    default: v = 0;
                endcase
            end
            8: v = longint'(act_q) + longint'($urandom_range(0, 4)) - 2;
            9: v = longint'($urandom_range(0, 64)) - 32;
            default: v = -h + (longint'($urandom()) % (2 * h + 1));
        endcase
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic queue_particle(input logic signed [31:0] distance, input logic last,
                                  input bit may_idle);
        t_particle p;
        p.distance = distance;
        p.last     = last;
        p.gap      = may_idle ? $urandom_range(0, 6) : 0;
        particle_queue = {particle_queue, p};
    endtask

    task automatic queue_random(input int count);
        for (int k = 0; k < count; k++) begin
            queue_particle(pick_distance(), ($urandom_range(0, 15) == 0), (k / 60) % 3 != 1);
        end
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic put_reg(input shmol_pkg::t_cfg_index idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!o_cfg_ready);
        case (idx)
            shmol_pkg::CFG_MOLLIFY_WIDTH:     width_q = value[30:0];
            shmol_pkg::CFG_INV_MOLLIFY_WIDTH: inv_q   = value;
            default:                          act_q   = value;
        endcase
    endtask

    task automatic load_setting(input logic [30:0] w, input logic [31:0] inv,
                                input logic [31:0] act);
        put_reg(shmol_pkg::CFG_MOLLIFY_WIDTH, {1'b0, w});
        put_reg(shmol_pkg::CFG_INV_MOLLIFY_WIDTH, inv);
        put_reg(shmol_pkg::CFG_ACTIVE_DISTANCE, act);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (particle_queue.size() != 0 || in_valid || chi_pending.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Request driver: each request waits out its own gap before it is offered.
    always @(posedge clk) begin : request_driver
        t_particle nxt;
        if (!rst_n) begin
            in_valid  <= 1'b0;
            send_wait = 0;
        end else begin
            if (in_valid && o_in_ready) begin
                chi_pending = {chi_pending, predict_chi(in_dist, in_last)};
                n_sent++;
            end
            if (!in_valid || o_in_ready) begin
                if (particle_queue.size() != 0 && send_wait >= particle_queue[0].gap) begin
                    nxt       = particle_queue.pop_front();
                    in_valid  <= 1'b1;
                    in_dist   <= nxt.distance;
                    in_last   <= nxt.last;
                    send_wait = 0;
                end else begin
                    in_valid <= 1'b0;
                    if (particle_queue.size() != 0) send_wait++;
                end
            end
        end
    end

    // Result monitor: checks in order, then draws its own stall.
    always @(posedge clk) begin : result_monitor
        t_chi_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rcv_gap   = 0;
        end else begin
            if (out_ready && o_out_valid) begin
                if (chi_pending.size() == 0) begin
                    report_mismatch($sformatf("result with no request pending, mask %0d",
                                              o_mask_value));
                end else begin
                    want = chi_pending.pop_front();
                    if (o_mask_value !== want.mask)
                        report_mismatch($sformatf("R=%0d: mask %0d, want %0d",
                                                  want.distance, o_mask_value, want.mask));
                    if (o_is_active !== want.active)
                        report_mismatch($sformatf("R=%0d: active %b, want %b",
                                                  want.distance, o_is_active, want.active));
                    if (o_last_out !== want.last)
                        report_mismatch($sformatf("R=%0d: last %b, want %b",
                                                  want.distance, o_last_out, want.last));
                end
                n_recv++;
                rcv_gap = ((n_recv / 100) % 3 == 2) ? 0 : $urandom_range(0, 6);
            end
            if (sink_hold) begin
                out_ready <= 1'b0;
            end else if (rcv_gap > 0) begin
                rcv_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // One long receiver stall while requests keep coming, so the pipeline
    // fills and backpressure reaches the input.
    initial begin : long_stall
        wait (n_sent >= 600);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (200) @(posedge clk);
        sink_hold <= 1'b0;
    end

    initial begin : stimulus
        logic signed [31:0] corner_dist [17];
        logic [30:0]        w_rand;
        longint             inv_rand;

        corner_dist = '{
            32'sd0, 32'sd1, -32'sd1, 32'sd65536, -32'sd65536, 32'sd65537, -32'sd65537,
            32'sd32768, -32'sd32768, 32'sd16384, -32'sd16384, 32'sd65535, -32'sd65535,
            32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA
        };
        for (int i = 0; i < 30; i++) begin
            atan_q30[i] = atan_pow2(i);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setting: h = 1.0, 1/h = 1.0, activation at 1.0.
        for (int k = 0; k < 17; k++) begin
            queue_particle(corner_dist[k], (k % 2) == 1, 1'b1);
        end
        queue_random(N_RANDOM);
        wait_drained();

        load_setting(31'd196608, 32'd21845, 32'h8000_0000);
        queue_random(N_RANDOM);
        wait_drained();

        load_setting(31'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF);
        queue_random(N_RANDOM);
        wait_drained();

        // Zero width: only R = 0 falls in the band.
        load_setting(31'd0, 32'd65536, 32'd0);
        queue_particle(32'sd0, 1'b1, 1'b1);
        queue_particle(32'sd1, 1'b0, 1'b1);
        queue_particle(-32'sd1, 1'b1, 1'b1);
        queue_random(N_RANDOM);
        wait_drained();

        // Reciprocal far too large, so u saturates inside the band.
        load_setting(31'd32768, 32'hFFFF_FFFF, 32'hFFFF_0000);
        queue_random(N_RANDOM);
        wait_drained();

        // Zero reciprocal gives chi = 0.5 across the band.
        load_setting(31'd262144, 32'd0, 32'h0002_0000);
        queue_random(N_RANDOM);
        wait_drained();

        load_setting(31'd1, 32'hFFFF_FFFF, $urandom());
        queue_random(N_RANDOM);
        wait_drained();

        w_rand   = 31'($urandom_range(1, 1 << 20));
        inv_rand = ((longint'(1) <<< 32) + longint'(w_rand) / 2) / longint'(w_rand);
        if (inv_rand > 64'sd4294967295) inv_rand = 64'sd4294967295;
        load_setting(w_rand, inv_rand[31:0], $urandom());
        queue_random(N_RANDOM);
        wait_drained();

        repeat (LATENCY + 8) @(posedge clk);
        if (chi_pending.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", chi_pending.size()));
        end
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
